// File: src/task_priority_ready_queue_defines.svh
// assertion macros shared by the rtl
`ifndef TASK_PRIORITY_READY_QUEUE_DEFINES_SVH
`define TASK_PRIORITY_READY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define TPRQ_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) else $error(msg);
`define TPRQ_NEVER(lbl, clk_s, rst_n_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(cond)) else $error(msg);
`else
`define TPRQ_ASSERT(lbl, clk_s, rst_n_s, prop, msg)
`define TPRQ_NEVER(lbl, clk_s, rst_n_s, cond, msg)
`endif

`endif

// File: src/tprq_pkg.sv
`default_nettype none
package tprq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 8;
	localparam int PRIO_BITS   = 8;
	localparam int FUNC_BITS   = 2;
	localparam int STATUS_BITS = 2;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef logic [FUNC_BITS-1:0]   func_t;
	typedef logic [STATUS_BITS-1:0] status_t;
	typedef logic [ID_BITS-1:0]     id_t;
	typedef logic [PRIO_BITS-1:0]   prio_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	localparam func_t FUNC_INSERT = 2'd0;
	localparam func_t FUNC_APPEND = 2'd1;
	localparam func_t FUNC_POP    = 2'd2;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_step;
		logic commit;
	} tprq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic  hit;
		logic  scan_end;
		logic  out_free;
	} tprq_stat_t;

endpackage
`default_nettype wire

// File: src/tprq_datapath.sv
`default_nettype none
`include "task_priority_ready_queue_defines.svh"
module tprq_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tprq_pkg::tprq_cmd_t  cmd,
	output tprq_pkg::tprq_stat_t      stat,
	input  wire tprq_pkg::func_t      func,
	input  wire tprq_pkg::id_t        task_id,
	input  wire tprq_pkg::prio_t      priority_req,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output tprq_pkg::id_t             out_task_id,
	output logic                      out_valid,
	output tprq_pkg::status_t         status,
	output tprq_pkg::cnt_t            occupancy
);
	import tprq_pkg::*;

	id_t     slot_task_q [QUEUE_DEPTH];
	prio_t   slot_prio_q [QUEUE_DEPTH];
	cnt_t    count_q;
	cnt_t    idx_q;
	cnt_t    pos_q;
	func_t   func_q;
	id_t     tid_q;
	prio_t   prio_q;
	logic    res_valid_q;
	id_t     out_task_id_q;
	logic    out_valid_q;
	status_t status_q;
	cnt_t    occupancy_q;

	logic    full;
	logic    empty;
	logic    do_ins;
	logic    do_pop;
	logic    in_range;
	logic    hit;
	cnt_t    count_nxt;
	status_t status_nxt;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign in_range = (idx_q < count_q);
	assign hit      = in_range && (prio_q > slot_prio_q[idx_q[IDX_W-1:0]]);

	assign stat.hit      = hit;
	assign stat.scan_end = !in_range;
	assign stat.out_free = !res_valid_q || res_ready;

	always_comb begin
		do_ins     = 1'b0;
		do_pop     = 1'b0;
		count_nxt  = count_q;
		status_nxt = ST_OK;
		case (func_q) inside
			FUNC_INSERT, FUNC_APPEND: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					do_ins    = 1'b1;
					count_nxt = count_q + 1'b1;
				end
			end
			FUNC_POP: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					do_pop    = 1'b1;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	// captured request and scan position
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			tid_q  <= task_id;
			prio_q <= priority_req;
			idx_q  <= '0;
			pos_q  <= count_q;
		end else if (cmd.scan_step) begin
			if (hit) begin
				pos_q <= idx_q;
			end else if (in_range) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// slot storage, shifted in place
	always_ff @(posedge clk) begin
		if (cmd.commit && do_ins) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (CNT_W'(i) == pos_q) begin
					slot_task_q[i] <= tid_q;
					slot_prio_q[i] <= prio_q;
				end else if (i > 0 && CNT_W'(i) > pos_q) begin
					slot_task_q[i] <= slot_task_q[(i > 0) ? i - 1 : 0];
					slot_prio_q[i] <= slot_prio_q[(i > 0) ? i - 1 : 0];
				end
			end
		end else if (cmd.commit && do_pop) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				slot_task_q[i] <= slot_task_q[i+1];
				slot_prio_q[i] <= slot_prio_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				count_q     <= count_nxt;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_task_id_q <= do_pop ? slot_task_q[0] : '0;
			out_valid_q   <= do_pop;
			status_q      <= status_nxt;
			occupancy_q   <= count_nxt;
		end
	end

	assign res_valid   = res_valid_q;
	assign out_task_id = out_task_id_q;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign occupancy   = occupancy_q;

	`TPRQ_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(QUEUE_DEPTH), "count beyond depth")
	`TPRQ_ASSERT(a_count_step, clk, arst_n, (count_q != $past(count_q)) |-> ((count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1)), "count moved by more than one")
	`TPRQ_NEVER(a_commit_overrun, clk, arst_n, cmd.commit && res_valid_q && !res_ready, "result overwritten before taken")
	`TPRQ_NEVER(a_pos_range, clk, arst_n, cmd.commit && (pos_q > count_q), "insert position past tail")

endmodule
`default_nettype wire

// File: src/tprq_ctrl.sv
`default_nettype none
`include "task_priority_ready_queue_defines.svh"
module tprq_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire tprq_pkg::func_t      func,
	input  wire tprq_pkg::tprq_stat_t stat,
	output tprq_pkg::tprq_cmd_t       cmd
);
	import tprq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt     = state_q;
		cmd.load      = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.commit    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = (func == FUNC_INSERT) ? S_SCAN : S_COMMIT;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.hit || stat.scan_end) begin
					state_nxt = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	`TPRQ_ASSERT(a_one_item, clk, arst_n, (in_valid && in_ready) |=> !in_ready, "item taken while busy")
	`TPRQ_NEVER(a_cmd_excl, clk, arst_n, (cmd.load && cmd.commit) || (cmd.scan_step && cmd.commit), "overlapping commands")
	`TPRQ_ASSERT(a_commit_idle, clk, arst_n, cmd.commit |=> in_ready, "no return to idle after commit")

endmodule
`default_nettype wire

// File: src/task_priority_ready_queue.sv
// Stable priority ready queue of up to 16 task identifiers.
// Input channel (in_valid/in_ready): func, task_id, priority_req. func selects
// insert by priority (placed behind all tasks of greater or equal priority),
// append at tail, or pop of the head task; the fourth code is a no-op.
// Result channel (res_valid/res_ready): one item per input item carrying
// out_task_id, out_valid, status and occupancy after the operation.
// Append, pop and no-op go from acceptance straight to the commit state;
// insert first walks the stored priorities one slot per cycle in the scan
// state, stopping at the first slot of lower priority or past the tail, so
// it passes at most the occupancy in slots. One item is worked at a time;
// in_ready returns in the same cycle as the registered result appears.
// A result waiting on a stalled receiver does not block the next item from
// being accepted and worked; only its commit waits until the result register
// is free.
// Reset empties the queue at once; slot contents are not cleared and are
// never read while unoccupied.
`default_nettype none
module task_priority_ready_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire tprq_pkg::func_t     func,
	input  wire tprq_pkg::id_t       task_id,
	input  wire tprq_pkg::prio_t     priority_req,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output tprq_pkg::id_t            out_task_id,
	output logic                     out_valid,
	output tprq_pkg::status_t        status,
	output tprq_pkg::cnt_t           occupancy
);
	import tprq_pkg::*;

	tprq_cmd_t  cmd;
	tprq_stat_t stat;

	tprq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.stat     (stat),
		.cmd      (cmd)
	);

	tprq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (func),
		.task_id      (task_id),
		.priority_req (priority_req),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.out_task_id  (out_task_id),
		.out_valid    (out_valid),
		.status       (status),
		.occupancy    (occupancy)
	);

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import tprq_pkg::*;

	localparam func_t FUNC_NOP = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		id_t     task_id;
		logic    valid;
		status_t st;
		cnt_t    occ;
	} ready_result_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	func_t   func = FUNC_NOP;
	id_t     task_id = '0;
	prio_t   priority_req = '0;
	logic    res_valid;
	logic    res_ready = 1'b0;
	id_t     out_task_id;
	logic    out_valid;
	status_t status;
	cnt_t    occupancy;

	// own copy of the queue contents, head at index 0
	id_t   ready_slot_task [QUEUE_DEPTH];
	prio_t ready_slot_prio [QUEUE_DEPTH];
	int    ready_count = 0;

	ready_result_t awaited_results[$];
	int fail_count = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;

	task_priority_ready_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.task_id      (task_id),
		.priority_req (priority_req),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.out_task_id  (out_task_id),
		.out_valid    (out_valid),
		.status       (status),
		.occupancy    (occupancy)
	);

	always #2 clk = ~clk;

	function automatic ready_result_t next_ready_result(func_t f, id_t id, prio_t p);
		ready_result_t r;
		int pos;
		r = '0;
		if (f == FUNC_INSERT || f == FUNC_APPEND) begin
			if (ready_count >= QUEUE_DEPTH) begin
				r.st = ST_FULL;
			end else begin
				pos = ready_count;
				if (f == FUNC_INSERT) begin
					for (int i = ready_count - 1; i >= 0; i--) begin
						if (p > ready_slot_prio[i])
							pos = i;
					end
				end
				for (int i = ready_count; i > pos; i--) begin
					ready_slot_task[i] = ready_slot_task[i - 1];
					ready_slot_prio[i] = ready_slot_prio[i - 1];
				end
				ready_slot_task[pos] = id;
				ready_slot_prio[pos] = p;
				ready_count++;
			end
		end else if (f == FUNC_POP) begin
			if (ready_count == 0) begin
				r.st = ST_EMPTY;
			end else begin
				r.task_id = ready_slot_task[0];
				r.valid = 1'b1;
				for (int i = 1; i < ready_count; i++) begin
					ready_slot_task[i - 1] = ready_slot_task[i];
					ready_slot_prio[i - 1] = ready_slot_prio[i];
				end
				ready_count--;
			end
		end
		r.occ = cnt_t'(ready_count);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		fail_count++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
	endtask

	// entered and left at a falling edge
	task automatic send_item(func_t f, id_t id, prio_t p);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		task_id = id;
		priority_req = p;
		do @(posedge clk); while (!in_ready);
		awaited_results.push_back(next_ready_result(f, id, p));
		@(negedge clk);
	endtask

	task automatic test_directed;
		gap_pct = 20;
		stall_pct = 20;
		send_item(FUNC_POP, 8'h5a, 8'ha5);
		send_item(FUNC_NOP, 8'hff, 8'hff);
		send_item(FUNC_INSERT, 8'h00, 8'h00);
		send_item(FUNC_INSERT, 8'hff, 8'hff);
		send_item(FUNC_INSERT, 8'h11, 8'h80);
		send_item(FUNC_INSERT, 8'h12, 8'h80);
		send_item(FUNC_APPEND, 8'h13, 8'hff);
		send_item(FUNC_INSERT, 8'h14, 8'h00);
		send_item(FUNC_INSERT, 8'h15, 8'h80);
		send_item(FUNC_POP, 8'h00, 8'h00);
		for (int k = 0; k < 10; k++)
			send_item(FUNC_INSERT, id_t'(8'h20 + k), prio_t'($urandom_range(255)));
		send_item(FUNC_INSERT, 8'haa, 8'hff);
		send_item(FUNC_APPEND, 8'h55, 8'h00);
		send_item(FUNC_NOP, 8'h00, 8'h00);
		send_item(FUNC_POP, 8'hff, 8'hff);
	endtask

	task automatic test_random_mix(int n_items, bit allow_idle);
		bit filling;
		int r;
		func_t f;
		prio_t p;
		filling = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			if (i % 150 == 0) begin
				gap_pct = (allow_idle && ((i / 150) % 2 == 0)) ? 30 : 0;
				stall_pct = (allow_idle && ((i / 150) % 3 != 2)) ? 30 : 0;
			end
			if (ready_count == QUEUE_DEPTH && $urandom_range(1) == 0)
				filling = 1'b0;
			else if (ready_count == 0)
				filling = 1'b1;
			else if ($urandom_range(39) == 0)
				filling = ~filling;
			r = $urandom_range(99);
			if (r < 3)
				f = FUNC_NOP;
			else if (filling)
				f = (r < 58) ? FUNC_INSERT : (r < 73) ? FUNC_APPEND : FUNC_POP;
			else
				f = (r < 68) ? FUNC_POP : (r < 88) ? FUNC_INSERT : FUNC_APPEND;
			case ($urandom_range(3))
				0: p = $urandom_range(1) ? 8'hff : 8'h00;
				1: p = prio_t'($urandom_range(3));
				default: p = prio_t'($urandom_range(255));
			endcase
			send_item(f, id_t'($urandom_range(255)), p);
		end
	endtask

	// receiver holds off long enough for the result register to fill and stall the input
	task automatic test_backpressure;
		gap_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 30; i++)
			send_item(func_t'($urandom_range(2)), id_t'($urandom_range(255)),
				prio_t'($urandom_range(255)));
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed;
		test_random_mix(1570, 1'b1);
		test_backpressure;
		test_random_mix(230, 1'b0);
		in_valid = 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("** task_priority_ready_queue: PASSED **");
		else
			$display("** task_priority_ready_queue: FAILED **");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				res_ready = 1'b0;
				repeat ($urandom_range(0, 8)) @(negedge clk);
			end else begin
				res_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		ready_result_t want;
		if (arst_n && res_valid && res_ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result item", occupancy, 0);
			end else begin
				want = awaited_results.pop_front();
				if (out_task_id !== want.task_id)
					report_mismatch("out_task_id", out_task_id, want.task_id);
				if (out_valid !== want.valid)
					report_mismatch("out_valid", out_valid, want.valid);
				if (status !== want.st)
					report_mismatch("status", status, want.st);
				if (occupancy !== want.occ)
					report_mismatch("occupancy", occupancy, want.occ);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("** task_priority_ready_queue: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
